>>> rtl/core/moving_average_min_max_unit_defines.svh
// Assertion macros for the moving average unit.
// The macros assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef MOVING_AVERAGE_MIN_MAX_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_MIN_MAX_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks that the consequent holds in the same cycle as the antecedent.
`define MAMM_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("moving average unit: same-cycle check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define MAMM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("moving average unit: next-cycle check failed");
`else
`define MAMM_ASSERT_IMPL(name, pre, post)
`define MAMM_ASSERT_NEXT(name, pre, post)
`endif

`endif

>>> rtl/core/mamm_pkg.sv
package mamm_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SampleBits       = 16;
  localparam int unsigned CfgBits          = 7;
  localparam int unsigned WindowMaxDefault = 64;

  typedef logic signed [SampleBits-1:0] sample_t;

  // Extreme values used to seed the min and max trackers.
  localparam sample_t SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  // Input transfer payload.
  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } in_item_t;

  // Output transfer payload.
  typedef struct packed {
    sample_t min_average;
    sample_t max_average;
    logic    has_window;
  } out_item_t;

  // Control from the sequencer to the extreme tracker.
  typedef struct packed {
    logic update;
    logic clear;
  } trk_ctrl_t;

  // Status from the extreme tracker.
  typedef struct packed {
    sample_t least;
    sample_t greatest;
    logic    seen;
  } trk_stat_t;

endpackage

>>> rtl/core/moving_average_min_max_unit.sv
// Moving average unit with min/max tracking. Each input transfer carries one
// signed sample; the unit keeps the last window_length samples of the current
// sequence in a ring memory with a running sum, and every sample that completes
// a window yields an average (sum divided by the window length, truncated toward
// zero) that updates the least and greatest averages seen. The transfer marked
// last_sample produces one output transfer with both extremes and has_window;
// when no full window occurred, has_window is 0 and both averages read 0. The
// sequence state is then cleared, as it is by any write of window_length (0 is
// taken as 1, values above WINDOW_MAX as WINDOW_MAX). A sample that completes a
// window holds in_ready low until the bit-serial divider, which yields one
// quotient bit per cycle, has finished; no new sample is taken before the last
// one has passed through the sequencer. A pending output transfer does not block
// new samples, only the report of the next sequence end.
`include "moving_average_min_max_unit_defines.svh"

module moving_average_min_max_unit #(
  parameter int unsigned WINDOW_MAX = mamm_pkg::WindowMaxDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mamm_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mamm_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mamm_pkg::CfgBits-1:0]      cfg_wdata_i
);
  import mamm_pkg::*;

  localparam int unsigned PtrW = $clog2(WINDOW_MAX);
  localparam int unsigned LenW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CmpW = (LenW > CfgBits) ? LenW : CfgBits;
  localparam int unsigned SumW = SampleBits + PtrW;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSum    = 4'b0010,
    StDiv    = 4'b0100,
    StReport = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CfgBits-1:0]    wl_q;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [LenW-1:0]       fill_q, fill_d;
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic                  full_q;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q;
  sample_t               sample_q;
  logic                  last_q;

  logic [CmpW-1:0]       wl_ext;
  logic [LenW-1:0]       len;
  logic [PtrW:0]         old_sum;
  logic [PtrW-1:0]       old_idx;
  logic                  full_now;
  logic                  accept;
  sample_t               old_sample;
  logic [LenW-1:0]       fill_inc;
  logic                  window;
  logic                  div_start;
  logic                  div_done;
  sample_t               avg;
  logic                  report;
  logic                  seq_clear;
  trk_ctrl_t             trk_ctrl;
  trk_stat_t             stat;

  // Active window length, clamped to one and to the ring depth.
  assign wl_ext = CmpW'(wl_q);
  always_comb begin
    if (wl_q == '0) begin
      len = LenW'(1);
    end else if (wl_ext > CmpW'(WINDOW_MAX)) begin
      len = LenW'(WINDOW_MAX);
    end else begin
      len = wl_ext[LenW-1:0];
    end
  end

  // Ring slot of the sample that drops out of the window.
  assign old_sum  = (PtrW+1)'(ptr_q) + (PtrW+1)'(WINDOW_MAX) - (PtrW+1)'(len);
  assign old_idx  = (old_sum >= (PtrW+1)'(WINDOW_MAX)) ?
                    PtrW'(old_sum - (PtrW+1)'(WINDOW_MAX)) : old_sum[PtrW-1:0];
  assign full_now = (fill_q >= len);

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  mamm_ring #(
    .Depth(WINDOW_MAX)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (state_q == StSum),
    .wr_addr_i(ptr_q),
    .wr_data_i(sample_q),
    .rd_en_i  (accept),
    .rd_addr_i(old_idx),
    .rd_data_o(old_sample)
  );

  // Window bookkeeping for the sample being absorbed.
  assign fill_inc = full_q ? fill_q : (fill_q + LenW'(1));
  assign window   = (fill_inc >= len);

  always_comb begin
    sum_d = sum_q + {{(SumW-SampleBits){sample_q[SampleBits-1]}}, sample_q};
    if (full_q) begin
      sum_d = sum_d - {{(SumW-SampleBits){old_sample[SampleBits-1]}}, old_sample};
    end
  end

  assign div_start = (state_q == StSum) && window;

  mamm_div #(
    .SumW(SumW),
    .LenW(LenW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_d),
    .divisor_i (len),
    .done_o    (div_done),
    .quotient_o(avg)
  );

  // A sequence end is reported once the output register is free.
  assign report    = (state_q == StReport) && last_q && (!out_valid_q || out_ready_i);
  assign seq_clear = report || cfg_we_i;

  assign trk_ctrl.update = (state_q == StDiv) && div_done;
  assign trk_ctrl.clear  = seq_clear;

  mamm_track u_track (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(trk_ctrl),
    .avg_i (avg),
    .stat_o(stat)
  );

  // Sequencer and sequence state.
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ptr_d   = ptr_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSum;
        end
      end
      StSum: begin
        fill_d  = fill_inc;
        ptr_d   = (ptr_q == PtrW'(WINDOW_MAX - 1)) ? '0 : (ptr_q + PtrW'(1));
        state_d = window ? StDiv : StReport;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StReport;
        end
      end
      StReport: begin
        if (!last_q || report) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (seq_clear) begin
      fill_d = '0;
      ptr_d  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (report) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wl_q        <= CfgBits'(1);
      sum_q       <= '0;
      fill_q      <= '0;
      ptr_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      if (seq_clear) begin
        sum_q <= '0;
      end else if (state_q == StSum) begin
        sum_q <= sum_d;
      end
      if (accept) begin
        full_q <= full_now;
      end
    end
  end

  // Payload registers for the accepted sample and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_data_i.sample;
      last_q   <= in_data_i.last_sample;
    end
    if (report) begin
      out_q.min_average <= stat.seen ? stat.least : '0;
      out_q.max_average <= stat.seen ? stat.greatest : '0;
      out_q.has_window  <= stat.seen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MAMM_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_q <= len)
  `MAMM_ASSERT_IMPL(a_done_in_div, div_done, state_q == StDiv)
  `MAMM_ASSERT_IMPL(a_empty_result_zero, out_valid_q && !out_q.has_window,
                    out_q.min_average == '0 && out_q.max_average == '0)
  `MAMM_ASSERT_IMPL(a_extremes_ordered, stat.seen, stat.least <= stat.greatest)
  `MAMM_ASSERT_NEXT(a_accept_to_sum, accept, state_q == StSum)

endmodule

>>> rtl/core/mamm_ring.sv
module mamm_ring #(
  parameter int unsigned Depth = mamm_pkg::WindowMaxDefault,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  mamm_pkg::sample_t wr_data_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output mamm_pkg::sample_t rd_data_o
);
  import mamm_pkg::*;

  sample_t mem_q [Depth];
  sample_t rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/mamm_div.sv
module mamm_div #(
  parameter int unsigned SumW = 22,
  parameter int unsigned LenW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic [LenW-1:0]        divisor_i,
  output logic                   done_o,
  output mamm_pkg::sample_t      quotient_o
);
  import mamm_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SumW-1:0]     quo_q, quo_d;
  logic [LenW-1:0]     rem_q, rem_d;
  logic                neg_q, neg_d;
  logic [LenW:0]       shifted;
  logic [LenW:0]       trial;
  logic                fits;
  logic [SampleBits-1:0] mag;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[SumW-1]};
  assign trial   = shifted - {1'b0, divisor_i};
  assign fits    = ~trial[LenW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(SumW);
      rem_d  = '0;
      neg_d  = dividend_i[SumW-1];
      quo_d  = dividend_i[SumW-1] ? SumW'(-dividend_i) : SumW'(dividend_i);
    end else if (busy_q) begin
      quo_d = {quo_q[SumW-2:0], fits};
      rem_d = fits ? trial[LenW-1:0] : shifted[LenW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  // The magnitude never exceeds half the sample range, so the low bits suffice.
  assign mag        = quo_q[SampleBits-1:0];
  assign quotient_o = neg_q ? sample_t'(-mag) : sample_t'(mag);
  assign done_o     = done_q;

endmodule

>>> rtl/core/mamm_track.sv
module mamm_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mamm_pkg::trk_ctrl_t ctrl_i,
  input  mamm_pkg::sample_t   avg_i,
  output mamm_pkg::trk_stat_t stat_o
);
  import mamm_pkg::*;

  sample_t least_q, least_d;
  sample_t greatest_q, greatest_d;
  logic    seen_q, seen_d;

  // Keep the running extremes of the window averages.
  always_comb begin
    least_d    = least_q;
    greatest_d = greatest_q;
    seen_d     = seen_q;
    if (ctrl_i.clear) begin
      least_d    = SampleMax;
      greatest_d = SampleMin;
      seen_d     = 1'b0;
    end else if (ctrl_i.update) begin
      if (avg_i < least_q) begin
        least_d = avg_i;
      end
      if (avg_i > greatest_q) begin
        greatest_d = avg_i;
      end
      seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q    <= SampleMax;
      greatest_q <= SampleMin;
      seen_q     <= 1'b0;
    end else begin
      least_q    <= least_d;
      greatest_q <= greatest_d;
      seen_q     <= seen_d;
    end
  end

  assign stat_o.least    = least_q;
  assign stat_o.greatest = greatest_q;
  assign stat_o.seen     = seen_q;

endmodule
